// ===== src/fps_pkg.sv =====
// ----------------------------------------------------------------------------
// fps_pkg: shared definitions of the feedback priority thread scheduler
// Sizes, event codes, the slot addressing function and the structs that
// pass between the level bookkeeping and the top level.
// ----------------------------------------------------------------------------
package fps_pkg;

  localparam int unsigned LEVELS      = 20;
  localparam int unsigned MAX_THREADS = 16;

  // Fixed widths of the item fields.
  localparam int unsigned ACT_W = 3;
  localparam int unsigned TID_W = 4;
  localparam int unsigned LVL_W = 5;

  // Derived sizes.
  localparam int unsigned LIDX_W     = $clog2(LEVELS);
  localparam int unsigned IDX_W      = $clog2(MAX_THREADS);
  localparam int unsigned CNT_W      = $clog2(MAX_THREADS + 1);
  localparam int unsigned SLOT_DEPTH = LEVELS * MAX_THREADS;
  localparam int unsigned SLOT_AW    = $clog2(SLOT_DEPTH);

  // Event codes.
  localparam logic [ACT_W-1:0] ACT_NEW     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_BLOCK   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_END     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_UNBLOCK = 3'd3;
  localparam logic [ACT_W-1:0] ACT_TIMER   = 3'd4;

  typedef struct packed {
    logic              valid;
    logic [LIDX_W-1:0] lvl;
  } lvl_req_t;

  typedef struct packed {
    logic              any;    // at least one level holds a thread
    logic [LIDX_W-1:0] first;  // highest priority non-empty level
  } lvl_stat_t;

  // Ring index advance with wrap at the level depth.
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(MAX_THREADS - 1)) begin
      res = '0;
    end else begin
      res = idx + IDX_W'(1);
    end
    return res;
  endfunction

  // Slot memory address of one ring position of one level.
  function automatic logic [SLOT_AW-1:0] slot_addr(input logic [LIDX_W-1:0] lvl,
                                                    input logic [IDX_W-1:0]  idx);
    logic [SLOT_AW-1:0] base;
    base = SLOT_AW'(SLOT_AW'(lvl) * SLOT_AW'(MAX_THREADS));
    return SLOT_AW'(base + SLOT_AW'(idx));
  endfunction

endpackage

// ===== src/fps_if.sv =====
// ----------------------------------------------------------------------------
// fps_if: channel interfaces of the thread scheduler
// Event channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface fps_in_if import fps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [TID_W-1:0] thread_id;

  modport source (output valid, output action, output thread_id, input ready);
  modport sink   (input valid, input action, input thread_id, output ready);
endinterface

interface fps_out_if import fps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             switched;
  logic [TID_W-1:0] old_thread;
  logic [TID_W-1:0] new_thread;
  logic [LVL_W-1:0] new_level;
  logic             none_ready;
  logic             overflow;

  modport source (output valid, output switched, output old_thread, output new_thread,
                  output new_level, output none_ready, output overflow, input ready);
  modport sink   (input valid, input switched, input old_thread, input new_thread,
                  input new_level, input none_ready, input overflow, output ready);
endinterface

// ===== src/fps_ram.sv =====
// ----------------------------------------------------------------------------
// fps_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fps_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 320,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/fps_lvl.sv =====
// ----------------------------------------------------------------------------
// fps_lvl: per-level ring pointers and occupancy
// Keeps head, tail and count of every level and finds the highest
// priority level that holds a thread.
// ----------------------------------------------------------------------------
module fps_lvl import fps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lvl_req_t         push_i,
  input  lvl_req_t         pop_i,
  output logic [IDX_W-1:0] tail_o,
  output logic             full_o,
  output logic [IDX_W-1:0] head_o,
  output lvl_stat_t        stat_o
);

  logic [IDX_W-1:0] head_q  [LEVELS];
  logic [IDX_W-1:0] tail_q  [LEVELS];
  logic [CNT_W-1:0] count_q [LEVELS];
  logic [LEVELS-1:0] nonempty;

  assign tail_o = tail_q[push_i.lvl];
  assign full_o = (count_q[push_i.lvl] == CNT_W'(MAX_THREADS));
  assign head_o = head_q[pop_i.lvl];

  always_comb begin
    stat_o.any   = 1'b0;
    stat_o.first = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      nonempty[i] = (count_q[i] != '0);
      if (nonempty[i]) begin
        stat_o.any   = 1'b1;
        stat_o.first = LIDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < LEVELS; i++) begin
        if (push_i.valid && push_i.lvl == LIDX_W'(i)) begin
          tail_q[i] <= next_idx(tail_q[i]);
        end
        if (pop_i.valid && pop_i.lvl == LIDX_W'(i)) begin
          head_q[i] <= next_idx(head_q[i]);
        end
        if ((push_i.valid && push_i.lvl == LIDX_W'(i)) &&
            !(pop_i.valid && pop_i.lvl == LIDX_W'(i))) begin
          count_q[i] <= count_q[i] + CNT_W'(1);
        end else if (!(push_i.valid && push_i.lvl == LIDX_W'(i)) &&
                     (pop_i.valid && pop_i.lvl == LIDX_W'(i))) begin
          count_q[i] <= count_q[i] - CNT_W'(1);
        end
      end
    end
  end

endmodule

// ===== src/feedback_priority_thread_scheduler.sv =====
// ----------------------------------------------------------------------------
// feedback_priority_thread_scheduler: multilevel feedback thread scheduler
// Ready levels as FIFO rings in one slot memory, dispatch on block, end
// and timer tick, with demotion of the preempted thread.
// ----------------------------------------------------------------------------
// The scheduler takes one event at a time and returns exactly one result
// per event. New-thread and unblock events go from decode straight to the
// result state; block, end and timer tick events first pass the pop state.
// The next event is taken in the cycle after the result is registered.
// The slot memory sets the pace of a dispatch: a level's enqueue is
// written in the decode state, the dispatch read is issued the next
// cycle, and its data arrives in the cycle after that. A waiting result
// does not hold off the next event; only the completion of that event
// waits for it.
// ----------------------------------------------------------------------------
module feedback_priority_thread_scheduler import fps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  fps_in_if.sink    in_i,
  fps_out_if.source out_o
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for an event
  localparam logic [1:0] S_EXEC = 2'd1;  // decode and enqueue
  localparam logic [1:0] S_POP  = 2'd2;  // pick a level and issue the slot read
  localparam logic [1:0] S_DONE = 2'd3;  // build the result

  logic [1:0]       state_q, state_d;
  logic [ACT_W-1:0] act_q;
  logic [TID_W-1:0] tid_q;
  logic [TID_W-1:0] run_tid_q;
  logic [LVL_W-1:0] run_lvl_q;
  logic             need_sw_q;
  logic             ovf_q;
  logic             any_q;
  logic [LIDX_W-1:0] pop_lvl_q;

  logic             out_valid_q;
  logic             out_sw_q;
  logic [TID_W-1:0] out_old_q;
  logic [TID_W-1:0] out_new_q;
  logic [LVL_W-1:0] out_lvl_q;
  logic             out_none_q;
  logic             out_ovf_q;

  // Decode of the held event.
  logic             is_enq;
  logic             is_drop;
  logic             is_tick;
  logic [LVL_W-1:0] push_lvl;
  logic [TID_W-1:0] push_tid;

  lvl_req_t         push_req;
  lvl_req_t         pop_req;
  logic [IDX_W-1:0] tail;
  logic [IDX_W-1:0] head;
  logic             full;
  lvl_stat_t        stat;
  logic [TID_W-1:0] slot_rdata;

  logic             in_xfer;
  logic             done_fire;
  logic             sw;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;

  always_comb begin
    is_enq  = act_q inside {ACT_NEW, ACT_UNBLOCK};
    is_drop = act_q inside {ACT_BLOCK, ACT_END};
    is_tick = (act_q == ACT_TIMER);
  end

  // A preempted thread sinks one level when someone else is waiting and it
  // is above the lowest level, else it stays on its level. The check for
  // waiting threads is made before the thread itself is queued.
  always_comb begin
    if (is_tick) begin
      push_tid = run_tid_q;
      if (run_lvl_q < LVL_W'(LEVELS - 1) && stat.any) begin
        push_lvl = run_lvl_q + LVL_W'(1);
      end else begin
        push_lvl = run_lvl_q;
      end
    end else begin
      push_tid = tid_q;
      push_lvl = '0;
    end
  end

  // The enqueue is written in the decode cycle; the dispatch read follows
  // in the next cycle, so a thread that was just queued is already visible
  // to it and no bypass around the slot memory is needed.
  always_comb begin
    push_req.lvl   = push_lvl[LIDX_W-1:0];
    push_req.valid = (state_q == S_EXEC) && (is_enq || is_tick) && !full;
    pop_req.lvl    = stat.first;
    pop_req.valid  = (state_q == S_POP) && stat.any;
  end

  fps_lvl u_lvl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_req),
    .pop_i  (pop_req),
    .tail_o (tail),
    .full_o (full),
    .head_o (head),
    .stat_o (stat)
  );

  fps_ram #(
    .Width (TID_W),
    .Depth (SLOT_DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (push_req.valid),
    .waddr_i (slot_addr(push_req.lvl, tail)),
    .wdata_i (push_tid),
    .re_i    (pop_req.valid),
    .raddr_i (slot_addr(stat.first, head)),
    .rdata_o (slot_rdata)
  );

  // The result register is free when it is empty or drained in this cycle.
  assign done_fire = (state_q == S_DONE) && (!out_valid_q || out_o.ready);
  assign sw        = need_sw_q && any_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (is_drop || is_tick) begin
          state_d = S_POP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_POP: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (done_fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_tid_q   <= '0;
      run_lvl_q   <= '0;
      need_sw_q   <= 1'b0;
      ovf_q       <= 1'b0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EXEC) begin
        need_sw_q <= is_drop || is_tick;
        ovf_q     <= (is_enq || is_tick) && full;
        any_q     <= 1'b0;
      end
      if (state_q == S_POP) begin
        any_q <= stat.any;
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
        if (sw) begin
          run_tid_q <= slot_rdata;
          run_lvl_q <= LVL_W'(pop_lvl_q);
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q <= in_i.action;
      tid_q <= in_i.thread_id;
    end
    if (state_q == S_POP) begin
      pop_lvl_q <= stat.first;
    end
    if (done_fire) begin
      out_sw_q   <= sw;
      out_old_q  <= run_tid_q;
      out_new_q  <= sw ? slot_rdata : run_tid_q;
      out_lvl_q  <= sw ? LVL_W'(pop_lvl_q) : run_lvl_q;
      out_none_q <= need_sw_q && !any_q;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.switched   = out_sw_q;
  assign out_o.old_thread = out_old_q;
  assign out_o.new_thread = out_new_q;
  assign out_o.new_level  = out_lvl_q;
  assign out_o.none_ready = out_none_q;
  assign out_o.overflow   = out_ovf_q;

endmodule

// ===== src/fps_checker.sv =====
// ----------------------------------------------------------------------------
// fps_checker: port level checks of the thread scheduler
// Watches the event and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module fps_checker import fps_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             switched_i,
  input logic [TID_W-1:0] old_thread_i,
  input logic [TID_W-1:0] new_thread_i,
  input logic             none_ready_i
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before its transfer");

  // Events are handled one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("event taken while another is in progress");

  // A dispatch and an empty dispatch exclude each other.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(switched_i && none_ready_i))
    else $error("switched and none_ready both set");

  // Without a dispatch the running thread does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !switched_i |-> new_thread_i == old_thread_i)
    else $error("running thread changed without a switch");

endmodule

bind feedback_priority_thread_scheduler fps_checker u_fps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .switched_i   (out_o.switched),
  .old_thread_i (out_o.old_thread),
  .new_thread_i (out_o.new_thread),
  .none_ready_i (out_o.none_ready)
);

// ===== test/tb_feedback_priority_thread_scheduler.sv =====
// ----------------------------------------------------------------------------
// tb_feedback_priority_thread_scheduler: self-checking bench of the scheduler
// Sends thread events over the event channel, predicts every result with a
// behavioral copy of the ready levels and compares each result transfer
// field by field. Directed cases come first, then long random runs.
// ----------------------------------------------------------------------------
module tb_feedback_priority_thread_scheduler;
  import fps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [TID_W-1:0] tid_t;

  // Action codes the scheduler does not define. They must leave the state
  // alone and report the running thread with every flag clear.
  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = ACT_TIMER + 1'b1;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = '1;

  // The drain wait after the last expected result is long enough to catch a
  // stray extra result. The cycle limit allows about 1500 events that each
  // meet the longest sender gap and the longest receiver stall, several
  // times over.
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  // One expected result transfer.
  typedef struct packed {
    logic             switched;
    tid_t             old_thread;
    tid_t             new_thread;
    logic [LVL_W-1:0] new_level;
    logic             none_ready;
    logic             overflow;
  } sched_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  fps_in_if  event_if ();
  fps_out_if result_if ();

  feedback_priority_thread_scheduler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (event_if.sink),
    .out_o  (result_if.source)
  );

  always #1 clk_i = ~clk_i;

  int unsigned cycle_count = 0;
  int unsigned fail_count  = 0;

  // When set, neither the event sender nor the result receiver idles, so
  // events run back to back at the block's own rate.
  bit no_gaps = 1'b0;

  // Results predicted at each accepted event, oldest first.
  sched_result_t pending_results[$];

  // Behavioral copy of the ready levels: one ring per level plus the
  // thread that currently holds the processor.
  tid_t        ring_mem  [LEVELS][MAX_THREADS];
  int unsigned ring_head [LEVELS] = '{default: 0};
  int unsigned ring_tail [LEVELS] = '{default: 0};
  int unsigned ring_fill [LEVELS] = '{default: 0};
  tid_t        cur_thread = '0;
  int unsigned cur_level  = 0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic int unsigned threads_queued();
    int unsigned total;
    total = 0;
    for (int l = 0; l < LEVELS; l++) total += ring_fill[l];
    return total;
  endfunction

  // Appends a thread to the tail of one level. A full level drops it.
  function automatic bit level_push(input int unsigned lvl, input tid_t tid);
    if (ring_fill[lvl] >= MAX_THREADS) return 1'b0;
    ring_mem[lvl][ring_tail[lvl]] = tid;
    ring_tail[lvl] = (ring_tail[lvl] + 1) % MAX_THREADS;
    ring_fill[lvl]++;
    return 1'b1;
  endfunction

  // Applies one event to the level copy and returns the result it causes.
  function automatic sched_result_t schedule_event(input logic [ACT_W-1:0] act,
                                                   input tid_t tid);
    sched_result_t res;
    bit            switch_due;
    bit            found;
    int unsigned   lvl;
    res = '0;
    res.old_thread = cur_thread;
    switch_due = 1'b0;
    found = 1'b0;
    case (act)
      ACT_NEW, ACT_UNBLOCK: begin
        res.overflow = !level_push(0, tid);
      end
      ACT_BLOCK, ACT_END: begin
        switch_due = 1'b1;
      end
      ACT_TIMER: begin
        // The preempted thread sinks one level only when someone else is
        // waiting, and never below the lowest level.
        lvl = cur_level;
        if (lvl < LEVELS - 1 && threads_queued() != 0) lvl++;
        res.overflow = !level_push(lvl, cur_thread);
        switch_due = 1'b1;
      end
      default: begin
      end
    endcase
    if (switch_due) begin
      // Dispatch the head of the highest non-empty level. With every level
      // empty, the running thread and its level stay as they were.
      for (int l = 0; l < LEVELS; l++) begin
        if (!found && ring_fill[l] != 0) begin
          cur_thread = ring_mem[l][ring_head[l]];
          ring_head[l] = (ring_head[l] + 1) % MAX_THREADS;
          ring_fill[l]--;
          cur_level = l;
          found = 1'b1;
        end
      end
      res.switched = found;
      res.none_ready = !found;
    end
    res.new_thread = cur_thread;
    res.new_level = LVL_W'(cur_level);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Event side
  // --------------------------------------------------------------------------

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Draws an action code from relative weights.
  function automatic logic [ACT_W-1:0] pick_action(input int unsigned w_new,
                                                   input int unsigned w_unblock,
                                                   input int unsigned w_block,
                                                   input int unsigned w_end,
                                                   input int unsigned w_timer,
                                                   input int unsigned w_noise);
    int unsigned r;
    r = $urandom_range(0, w_new + w_unblock + w_block + w_end + w_timer + w_noise - 1);
    if (r < w_new) return ACT_NEW;
    r -= w_new;
    if (r < w_unblock) return ACT_UNBLOCK;
    r -= w_unblock;
    if (r < w_block) return ACT_BLOCK;
    r -= w_block;
    if (r < w_end) return ACT_END;
    r -= w_end;
    if (r < w_timer) return ACT_TIMER;
    return ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
  endfunction

  function automatic tid_t any_thread();
    return tid_t'($urandom_range(0, MAX_THREADS - 1));
  endfunction

  // Offers one event and returns at the edge where it is transferred. Valid
  // is only lowered when a gap precedes the event, so back-to-back events
  // never see valid dropped and raised in one time step.
  task automatic send_event(input logic [ACT_W-1:0] act, input tid_t tid);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      event_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    event_if.valid     <= 1'b1;
    event_if.action    <= act;
    event_if.thread_id <= tid;
    do @(posedge clk_i); while (event_if.ready !== 1'b1);
    pending_results.push_back(schedule_event(act, tid));
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // The receiver samples the channel at each edge, before its own update of
  // ready takes effect, and then decides whether to stall.
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    sched_result_t want;
    if (rst_ni === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no event waiting for it");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("switched",   8'(want.switched),   8'(result_if.switched));
        compare_field("old_thread", 8'(want.old_thread), 8'(result_if.old_thread));
        compare_field("new_thread", 8'(want.new_thread), 8'(result_if.new_thread));
        compare_field("new_level",  8'(want.new_level),  8'(result_if.new_level));
        compare_field("none_ready", 8'(want.none_ready), 8'(result_if.none_ready));
        compare_field("overflow",   8'(want.overflow),   8'(result_if.overflow));
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      result_if.ready <= 1'b0;
    end else begin
      if (!no_gaps && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      result_if.ready <= (stall_left == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Straight after reset nothing is queued. Block and end must flag that no
  // thread is ready, unused codes must change nothing, and a timer tick must
  // requeue thread 0 at its own level and dispatch it right back.
  task automatic test_empty_levels();
    send_event(ACT_BLOCK, '0);
    send_event(ACT_END, '1);
    send_event(ACT_UNUSED_LO, tid_t'(4'b1010));
    send_event(ACT_UNUSED_LO + 1'b1, tid_t'(4'b0101));
    send_event(ACT_UNUSED_HI, '1);
    send_event(ACT_TIMER, tid_t'(4'b1001));
  endtask

  // Fills the top level with new and unblocked threads until the next one
  // is dropped, then preempts so the running thread is demoted while the
  // top level is still full, and blocks it to dispatch again.
  task automatic test_top_level_overflow();
    for (int i = 0; i < MAX_THREADS; i++) begin
      send_event((i % 2 == 0) ? ACT_NEW : ACT_UNBLOCK, tid_t'(i));
    end
    send_event(ACT_NEW, '1);
    send_event(ACT_UNBLOCK, '0);
    send_event(ACT_TIMER, '0);
    send_event(ACT_BLOCK, tid_t'(4'b0110));
  endtask

  // Every kind of event at random, with stretches where neither side idles.
  task automatic test_random_mix(input int unsigned count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_event(pick_action(25, 15, 10, 10, 35, 5), any_thread());
    end
    no_gaps = 1'b0;
  endtask

  // Ends threads until no level holds any, then lets a handful of threads
  // take turns under a steady stream of timer ticks. A preemption sinks
  // the running thread one level while others wait, so they all end up
  // parked at the lowest level and keep rotating there.
  task automatic test_deep_demotion(input int unsigned count);
    while (threads_queued() != 0) send_event(ACT_END, any_thread());
    for (int i = 0; i < 3; i++) send_event(ACT_NEW, any_thread());
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      send_event(pick_action(3, 3, 3, 3, 86, 2), any_thread());
    end
    no_gaps = 1'b0;
  endtask

  // Mostly arrivals and preemptions, so the top level keeps overflowing and
  // the levels below it fill up as well.
  task automatic test_crowded_levels(input int unsigned count);
    for (int i = 0; i < count; i++) begin
      send_event(pick_action(35, 20, 4, 4, 35, 2), any_thread());
    end
  endtask

  // --------------------------------------------------------------------------
  // Run control
  // --------------------------------------------------------------------------

  always @(posedge clk_i) cycle_count++;

  // A hung handshake must not stall the run forever.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    event_if.valid     = 1'b0;
    event_if.action    = ACT_NEW;
    event_if.thread_id = '0;
    result_if.ready    = 1'b0;
    rst_ni             = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_levels();
    test_top_level_overflow();
    test_random_mix(600);
    test_deep_demotion(330);
    test_crowded_levels(300);

    // All events are in. Wait until every result has come back, then a
    // little longer so that a surplus result would still be seen.
    event_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
